### rtl/ctbt_pkg.sv
// ----------------------------------------------------------------------------
// ctbt_pkg
// Shared codes, widths and control types of the color threshold blob tracker.
// ----------------------------------------------------------------------------
package ctbt_pkg;

  localparam int CHAN_W   = 8;
  localparam int BOUNDS_W = 24;
  localparam int COUNT_W  = 21;
  localparam int DENS_W   = 12;
  localparam int SCALED_W = 31;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_PIXEL  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_START_OK   = 2'd0;
  localparam logic [1:0] STATUS_BAD_BOUNDS = 2'd1;
  localparam logic [1:0] STATUS_SUMMARY    = 2'd2;

  localparam logic [1:0] CFG_LOWER = 2'd0;
  localparam logic [1:0] CFG_UPPER = 2'd1;
  localparam logic [1:0] CFG_CHSEL = 2'd2;

  localparam logic [1:0] CHSEL_ALL = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT   = 21'd1048576;
  localparam logic [DENS_W-1:0]  DENSITY_LIMIT = 12'd4000;

  typedef enum logic [1:0] {
    DIV_CX,
    DIV_CY,
    DIV_DEN
  } div_sel_t;

  typedef struct packed {
    logic     pixel;
    logic     start;
    logic     prep;
    logic     area;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_store;
    logic     summary;
  } ctbt_cmd_t;

  typedef struct packed {
    logic div_done;
  } ctbt_stat_t;

endpackage

### rtl/color_threshold_blob_tracker.sv
// ----------------------------------------------------------------------------
// color_threshold_blob_tracker
// Pixel item: one per cycle while idle, no result; start item: result in the
// next cycle. Finish item: result after the area step and three passes
// through the one-bit-per-cycle shared divider (centre x, centre y, density).
// Synchronous active-high reset; config resets to full bounds, all channels.
// ----------------------------------------------------------------------------
module color_threshold_blob_tracker import ctbt_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [BOUNDS_W-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [CHAN_W-1:0]     chan0,
  input  logic [CHAN_W-1:0]     chan1,
  input  logic [CHAN_W-1:0]     chan2,
  input  logic [COORD_BITS-1:0] x_coord,
  input  logic [COORD_BITS-1:0] y_coord,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [COUNT_W-1:0]    pixel_count,
  output logic [COORD_BITS-1:0] x_min,
  output logic [COORD_BITS-1:0] y_min,
  output logic [COORD_BITS-1:0] x_max,
  output logic [COORD_BITS-1:0] y_max,
  output logic [COORD_BITS-1:0] col_mean,
  output logic [COORD_BITS-1:0] row_mean,
  output logic [DENS_W-1:0]     density,
  output logic                  degenerate_box
);

  ctbt_cmd_t  cmd;
  ctbt_stat_t stat;

  assign cfg_ready = 1'b1;

  ctbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .out_ready(out_ready),
    .stat     (stat),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  ctbt_dpath #(
    .COORD_BITS(COORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .chan0         (chan0),
    .chan1         (chan1),
    .chan2         (chan2),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .status        (status),
    .pixel_count   (pixel_count),
    .x_min         (x_min),
    .y_min         (y_min),
    .x_max         (x_max),
    .y_max         (y_max),
    .col_mean      (col_mean),
    .row_mean      (row_mean),
    .density       (density),
    .degenerate_box(degenerate_box)
  );

endmodule

### rtl/ctbt_div.sv
// ----------------------------------------------------------------------------
// ctbt_div
// Restoring divider, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module ctbt_div import ctbt_pkg::*; #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  assign trial = {rem, quot[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= num;
    end else if (busy) begin
      rem  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], qbit};
    end
  end

endmodule

### rtl/ctbt_ctrl.sv
// ----------------------------------------------------------------------------
// ctbt_ctrl
// Handshake and sequencing of the finish computation.
// ----------------------------------------------------------------------------
module ctbt_ctrl import ctbt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] command,
  input  logic       out_ready,
  input  ctbt_stat_t stat,
  output logic       in_ready,
  output logic       out_valid,
  output ctbt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AREA,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_SUMMARY
  } state_t;

  state_t   state;
  div_sel_t sel;
  logic     accept;

  assign in_ready = (state == S_IDLE) &&
                    (!out_valid || command == CMD_PIXEL || command == CMD_UNUSED);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = sel;
    cmd.pixel     = accept && (command == CMD_PIXEL);
    cmd.start     = accept && (command == CMD_START);
    cmd.prep      = accept && (command == CMD_FINISH);
    cmd.area      = (state == S_AREA);
    cmd.div_start = (state == S_DIV_LOAD);
    cmd.div_store = (state == S_DIV_RUN) && stat.div_done;
    cmd.summary   = (state == S_SUMMARY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= DIV_CX;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            out_valid <= 1'b1;
          end
          if (cmd.prep) begin
            state <= S_AREA;
          end
        end
        S_AREA: begin
          sel   <= DIV_CX;
          state <= S_DIV_LOAD;
        end
        S_DIV_LOAD: begin
          state <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          if (stat.div_done) begin
            unique case (sel)
              DIV_CX: begin
                sel   <= DIV_CY;
                state <= S_DIV_LOAD;
              end
              DIV_CY: begin
                sel   <= DIV_DEN;
                state <= S_DIV_LOAD;
              end
              default: begin
                state <= S_SUMMARY;
              end
            endcase
          end
        end
        S_SUMMARY: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ctbt_dpath.sv
// ----------------------------------------------------------------------------
// ctbt_dpath
// Config registers, pixel match, accumulators, divider and result register.
// ----------------------------------------------------------------------------
module ctbt_dpath import ctbt_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctbt_cmd_t             cmd,
  output ctbt_stat_t            stat,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [BOUNDS_W-1:0]   cfg_data,
  input  logic [CHAN_W-1:0]     chan0,
  input  logic [CHAN_W-1:0]     chan1,
  input  logic [CHAN_W-1:0]     chan2,
  input  logic [COORD_BITS-1:0] x_coord,
  input  logic [COORD_BITS-1:0] y_coord,
  output logic [1:0]            status,
  output logic [COUNT_W-1:0]    pixel_count,
  output logic [COORD_BITS-1:0] x_min,
  output logic [COORD_BITS-1:0] y_min,
  output logic [COORD_BITS-1:0] x_max,
  output logic [COORD_BITS-1:0] y_max,
  output logic [COORD_BITS-1:0] col_mean,
  output logic [COORD_BITS-1:0] row_mean,
  output logic [DENS_W-1:0]     density,
  output logic                  degenerate_box
);

  localparam int SUM_W  = COORD_BITS + COUNT_W - 1;
  localparam int AREA_W = 2 * COORD_BITS;
  localparam int NUM_W  = (SUM_W > SCALED_W) ? SUM_W : SCALED_W;
  localparam int DEN_W  = (AREA_W > COUNT_W) ? AREA_W : COUNT_W;

  logic [BOUNDS_W-1:0]   lower;
  logic [BOUNDS_W-1:0]   upper;
  logic [1:0]            chsel;

  logic [COUNT_W-1:0]    count;
  logic [COORD_BITS-1:0] left;
  logic [COORD_BITS-1:0] top;
  logic [COORD_BITS-1:0] right;
  logic [COORD_BITS-1:0] bottom;
  logic [SUM_W-1:0]      col_sum;
  logic [SUM_W-1:0]      row_sum;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [SCALED_W-1:0]   scaled;
  logic [AREA_W-1:0]     area;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [DENS_W-1:0]     dens;

  logic [CHAN_W-1:0]     pix [3];
  logic [2:0]            ch_ok;
  logic [2:0]            ch_bad;
  logic                  hit;
  logic                  bad;

  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic [NUM_W-1:0]      div_quot;
  logic                  div_done;

  assign pix[0] = chan0;
  assign pix[1] = chan1;
  assign pix[2] = chan2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ch_ok[k]  = (pix[k] >= lower[CHAN_W*k +: CHAN_W]) &&
                  (pix[k] <= upper[CHAN_W*k +: CHAN_W]);
      ch_bad[k] = lower[CHAN_W*k +: CHAN_W] > upper[CHAN_W*k +: CHAN_W];
    end
    hit = (chsel == CHSEL_ALL) ? (&ch_ok) : ch_ok[chsel];
    bad = |ch_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower <= '0;
      upper <= '1;
      chsel <= CHSEL_ALL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWER: lower <= cfg_data;
        CFG_UPPER: upper <= cfg_data;
        CFG_CHSEL: chsel <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.start && !bad)) begin
      count   <= '0;
      left    <= '1;
      top     <= '1;
      right   <= '0;
      bottom  <= '0;
      col_sum <= '0;
      row_sum <= '0;
    end else if (cmd.pixel && hit && (count != COUNT_LIMIT)) begin
      count   <= count + 1'b1;
      if (x_coord < left) begin
        left <= x_coord;
      end
      if (y_coord < top) begin
        top <= y_coord;
      end
      if (x_coord > right) begin
        right <= x_coord;
      end
      if (y_coord > bottom) begin
        bottom <= y_coord;
      end
      col_sum <= col_sum + SUM_W'(x_coord);
      row_sum <= row_sum + SUM_W'(y_coord);
    end
  end

  // count * 1000 = count * 1024 - count * 16 - count * 8
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dx     <= (right >= left) ? (right - left) : '0;
      dy     <= (bottom >= top) ? (bottom - top) : '0;
      scaled <= SCALED_W'({count, 10'b0}) - SCALED_W'({count, 4'b0}) -
                SCALED_W'({count, 3'b0});
    end
    if (cmd.area) begin
      area <= AREA_W'(dx) * AREA_W'(dy);
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_CX: begin
        div_num = NUM_W'(col_sum);
        div_den = DEN_W'(count);
      end
      DIV_CY: begin
        div_num = NUM_W'(row_sum);
        div_den = DEN_W'(count);
      end
      DIV_DEN: begin
        div_num = NUM_W'(scaled);
        div_den = DEN_W'(area);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  ctbt_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        DIV_CX:  cx <= div_quot[COORD_BITS-1:0];
        DIV_CY:  cy <= div_quot[COORD_BITS-1:0];
        DIV_DEN: dens <= (div_quot > NUM_W'(DENSITY_LIMIT)) ? DENSITY_LIMIT :
                         div_quot[DENS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      status         <= bad ? STATUS_BAD_BOUNDS : STATUS_START_OK;
      pixel_count    <= '0;
      x_min          <= '0;
      y_min          <= '0;
      x_max          <= '0;
      y_max          <= '0;
      col_mean       <= '0;
      row_mean       <= '0;
      density        <= '0;
      degenerate_box <= 1'b0;
    end else if (cmd.summary) begin
      status <= STATUS_SUMMARY;
      if (count == '0) begin
        pixel_count    <= '0;
        x_min          <= '0;
        y_min          <= '0;
        x_max          <= '0;
        y_max          <= '0;
        col_mean       <= '0;
        row_mean       <= '0;
        density        <= '0;
        degenerate_box <= 1'b0;
      end else begin
        pixel_count    <= count;
        x_min          <= left;
        y_min          <= top;
        x_max          <= right;
        y_max          <= bottom;
        col_mean       <= cx;
        row_mean       <= cy;
        density        <= (area == '0) ? '0 : dens;
        degenerate_box <= (area == '0);
      end
    end
  end

endmodule

### rtl/ctbt_checker.sv
// ----------------------------------------------------------------------------
// ctbt_checker
// Port-level checks of the blob tracker results, bound to the top level.
// ----------------------------------------------------------------------------
module ctbt_checker import ctbt_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            status,
  input logic [COUNT_W-1:0]    pixel_count,
  input logic [COORD_BITS-1:0] x_min,
  input logic [COORD_BITS-1:0] x_max,
  input logic [DENS_W-1:0]     density,
  input logic                  degenerate_box
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pixel_count))
    else $error("result changed while stalled");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_SUMMARY |->
      pixel_count == '0 && x_max == '0 && density == '0 && !degenerate_box)
    else $error("start result carries nonzero fields");

  a_no_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_SUMMARY && pixel_count == '0 |->
      density == '0 && !degenerate_box && x_min == '0)
    else $error("empty frame summary not zero");

  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate_box |-> density == '0 && status == STATUS_SUMMARY)
    else $error("degenerate box with density");

  a_density_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> density <= DENSITY_LIMIT && status <= STATUS_SUMMARY)
    else $error("density above limit or bad status");

endmodule

bind color_threshold_blob_tracker ctbt_checker #(
  .COORD_BITS(COORD_BITS)
) u_ctbt_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .pixel_count   (pixel_count),
  .x_min         (x_min),
  .x_max         (x_max),
  .density       (density),
  .degenerate_box(degenerate_box)
);

### test/tb_color_threshold_blob_tracker.sv
// ----------------------------------------------------------------------------
// tb_color_threshold_blob_tracker
// Self-checking bench for the color threshold blob tracker. Drives frames of
// pixels under a series of bound and channel settings, with random gaps on
// the input and output handshakes and one long output stall. Every result
// is checked against a bench-side model of the tracker's accumulators.
// ----------------------------------------------------------------------------
module tb_color_threshold_blob_tracker;
  import ctbt_pkg::*;

  localparam int CW          = 10;
  localparam int PHASE_ITEMS = 50;
  localparam int SETTLE      = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG    = 5000;
  localparam logic [1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic [CW-1:0]      x_min;
    logic [CW-1:0]      y_min;
    logic [CW-1:0]      x_max;
    logic [CW-1:0]      y_max;
    logic [CW-1:0]      cx;
    logic [CW-1:0]      cy;
    logic [DENS_W-1:0]  density;
    logic               deg;
  } summary_t;

  class blob_scoreboard;
    logic [BOUNDS_W-1:0] lo_bounds, hi_bounds;
    logic [1:0]          chsel;
    logic [COUNT_W-1:0]  hits;
    logic [CW-1:0]       left, top, right, bottom;
    logic [29:0]         col_sum, row_sum;
    summary_t            summary_q[$];
    int                  noted, checked, mismatches;

    function new();
      lo_bounds = '0;
      hi_bounds = '1;
      chsel = CHSEL_ALL;
      clear_frame();
    endfunction

    function void clear_frame();
      hits = '0;
      left = '1;
      top = '1;
      right = '0;
      bottom = '0;
      col_sum = '0;
      row_sum = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [BOUNDS_W-1:0] data);
      case (idx)
        CFG_LOWER: lo_bounds = data;
        CFG_UPPER: hi_bounds = data;
        CFG_CHSEL: chsel = data[1:0];
        default: ;
      endcase
    endfunction

    function bit in_range(logic [7:0] v, int k);
      return v >= lo_bounds[8*k +: 8] && v <= hi_bounds[8*k +: 8];
    endfunction

    function void note_item(logic [1:0] cmd, logic [7:0] c0, logic [7:0] c1,
                            logic [7:0] c2, logic [CW-1:0] x, logic [CW-1:0] y);
      summary_t        r;
      logic [7:0]      px [3];
      bit              hit, bad;
      int              k;
      longint unsigned dx, dy, area, dens;
      r = '0;
      px[0] = c0;
      px[1] = c1;
      px[2] = c2;
      if (cmd != CMD_UNUSED) noted++;
      case (cmd)
        CMD_PIXEL: begin
          if (chsel == CHSEL_ALL) hit = in_range(c0, 0) && in_range(c1, 1) && in_range(c2, 2);
          else hit = in_range(px[chsel], chsel);
          if (hit && hits < COUNT_LIMIT) begin
            hits = hits + 1'b1;
            if (x < left) left = x;
            if (y < top) top = y;
            if (x > right) right = x;
            if (y > bottom) bottom = y;
            col_sum = col_sum + 30'(x);
            row_sum = row_sum + 30'(y);
          end
        end
        CMD_START: begin
          bad = 1'b0;
          for (k = 0; k < 3; k++)
            if (lo_bounds[8*k +: 8] > hi_bounds[8*k +: 8]) bad = 1'b1;
          if (bad) begin
            r.status = STATUS_BAD_BOUNDS;
          end else begin
            clear_frame();
            r.status = STATUS_START_OK;
          end
          summary_q.push_back(r);
        end
        CMD_FINISH: begin
          r.status = STATUS_SUMMARY;
          if (hits != 0) begin
            dx = (right >= left) ? right - left : 0;
            dy = (bottom >= top) ? bottom - top : 0;
            area = dx * dy;
            if (area == 0) begin
              r.deg = 1'b1;
            end else begin
              dens = (64'(hits) * 1000) / area;
              if (dens > DENSITY_LIMIT) dens = DENSITY_LIMIT;
              r.density = dens[DENS_W-1:0];
            end
            r.count = hits;
            r.x_min = left;
            r.y_min = top;
            r.x_max = right;
            r.y_max = bottom;
            r.cx = CW'(col_sum / hits);
            r.cy = CW'(row_sum / hits);
          end
          summary_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, summary_t e, summary_t g);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0s: expected st=%0d n=%0d box=%0d,%0d..%0d,%0d c=%0d,%0d dens=%0d deg=%0d",
                 what, e.status, e.count, e.x_min, e.y_min, e.x_max, e.y_max,
                 e.cx, e.cy, e.density, e.deg);
        $display("  actual      st=%0d n=%0d box=%0d,%0d..%0d,%0d c=%0d,%0d dens=%0d deg=%0d",
                 g.status, g.count, g.x_min, g.y_min, g.x_max, g.y_max,
                 g.cx, g.cy, g.density, g.deg);
      end
    endfunction

    function void check_result(summary_t got);
      summary_t exp_r;
      checked++;
      if (summary_q.size() == 0) begin
        flag("unexpected result", '0, got);
      end else begin
        exp_r = summary_q.pop_front();
        if (got !== exp_r) flag("result mismatch", exp_r, got);
      end
    endfunction

    function int outstanding();
      return summary_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [BOUNDS_W-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          command = '0;
  logic [CHAN_W-1:0]   chan0 = '0;
  logic [CHAN_W-1:0]   chan1 = '0;
  logic [CHAN_W-1:0]   chan2 = '0;
  logic [CW-1:0]       x_coord = '0;
  logic [CW-1:0]       y_coord = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [COUNT_W-1:0]  pixel_count;
  logic [CW-1:0]       x_min, y_min, x_max, y_max;
  logic [CW-1:0]       col_mean, row_mean;
  logic [DENS_W-1:0]   density;
  logic                degenerate_box;

  blob_scoreboard sb;
  bit quiet = 1'b0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int phases = 0;

  color_threshold_blob_tracker #(.COORD_BITS(CW)) dut (.*);

  always #1 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] chan_value(int k);
    logic [7:0] l, h;
    l = sb.lo_bounds[8*k +: 8];
    h = sb.hi_bounds[8*k +: 8];
    if (l <= h && $urandom_range(0, 3) != 0) return 8'($urandom_range(l, h));
    return 8'($urandom);
  endfunction

  function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] center, int spread);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CW'(center + $urandom_range(0, spread));
  endfunction

  function automatic void random_bounds(output logic [BOUNDS_W-1:0] lo,
                                        output logic [BOUNDS_W-1:0] hi, input bit allow_bad);
    logic [7:0] a, b;
    int k;
    for (k = 0; k < 3; k++) begin
      a = 8'($urandom);
      b = 8'($urandom);
      if ((a > b) != (allow_bad && $urandom_range(0, 2) == 0)) begin
        lo[8*k +: 8] = b;
        hi[8*k +: 8] = a;
      end else begin
        lo[8*k +: 8] = a;
        hi[8*k +: 8] = b;
      end
    end
  endfunction

  // output side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result({status, pixel_count, x_min, y_min, x_max, y_max,
                         col_mean, row_mean, density, degenerate_box});
      if (hold_ask != hold_seen) begin
        hold_seen <= hold_ask;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                           logic [CW-1:0] x, logic [CW-1:0] y);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    chan0 <= c0;
    chan1 <= c1;
    chan2 <= c2;
    x_coord <= x;
    y_coord <= y;
    do @(posedge clk); while (!in_ready);
    sb.note_item(cmd, c0, c1, c2, x, y);
  endtask

  task automatic send_cmd(logic [1:0] cmd);
    send_item(cmd, 8'($urandom), 8'($urandom), 8'($urandom), CW'($urandom), CW'($urandom));
  endtask

  task automatic send_frame();
    int n, spread;
    logic [CW-1:0] cx0, cy0;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 2;
      2: spread = 40;
      default: spread = 1023;
    endcase
    cx0 = CW'($urandom);
    cy0 = CW'($urandom);
    send_cmd(CMD_START);
    repeat (n)
      send_item(CMD_PIXEL, chan_value(0), chan_value(1), chan_value(2),
                pick_coord(cx0, spread), pick_coord(cy0, spread));
    send_cmd(CMD_FINISH);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [BOUNDS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(logic [BOUNDS_W-1:0] lo, logic [BOUNDS_W-1:0] hi,
                               logic [1:0] sel);
    drain();
    cfg_write(CFG_LOWER, lo);
    cfg_write(CFG_UPPER, hi);
    cfg_write(CFG_CHSEL, {22'd0, sel});
  endtask

  task automatic run_phase(logic [BOUNDS_W-1:0] lo, logic [BOUNDS_W-1:0] hi,
                           logic [1:0] sel, bit q, bit squeeze);
    int first;
    apply_setting(lo, hi, sel);
    quiet <= q;
    if (squeeze) hold_ask <= hold_ask + 1;
    first = sb.noted;
    while (sb.noted - first < PHASE_ITEMS) begin
      if ($urandom_range(0, 6) == 0) send_cmd(2'($urandom));
      else send_frame();
    end
    phases++;
  endtask

  initial begin
    logic [BOUNDS_W-1:0] lo, hi;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // pixel ahead of any start lands in the reset state
    send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 10'd5, 10'd7);
    send_cmd(CMD_FINISH);
    send_cmd(CMD_START);
    send_cmd(CMD_FINISH);
    send_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, '1, '1);
    send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, '0, '0);
    send_item(CMD_PIXEL, 8'h00, 8'hFF, 8'h00, '1, '1);
    send_cmd(CMD_FINISH);
    // repeated coordinates push density past its ceiling
    send_cmd(CMD_START);
    repeat (3) send_item(CMD_PIXEL, 8'h12, 8'h34, 8'h56, 10'd10, 10'd10);
    repeat (2) send_item(CMD_PIXEL, 8'h80, 8'h80, 8'h80, 10'd11, 10'd11);
    send_cmd(CMD_FINISH);
    // single column gives a zero-area box
    send_cmd(CMD_START);
    send_item(CMD_PIXEL, 8'h01, 8'h02, 8'h03, 10'd3, 10'd0);
    send_item(CMD_PIXEL, 8'hFE, 8'hFD, 8'hFC, 10'd3, 10'd100);
    send_cmd(CMD_FINISH);
    // inverted channel 0 bounds: start refused, frame kept
    apply_setting(24'h000080, 24'h00007F, CHSEL_ALL);
    send_cmd(CMD_START);
    send_cmd(CMD_FINISH);
    drain();
    cfg_write(CFG_NONE, 24'($urandom));

    run_phase(24'h000000, 24'hFFFFFF, CHSEL_ALL, 1'b0, 1'b0);
    run_phase(24'hFFFFFF, 24'hFFFFFF, CHSEL_ALL, 1'b0, 1'b0);
    run_phase(24'h000000, 24'h000000, 2'd0, 1'b0, 1'b0);
    random_bounds(lo, hi, 1'b0);
    run_phase(lo, hi, 2'd1, 1'b0, 1'b0);
    random_bounds(lo, hi, 1'b0);
    run_phase(lo, hi, 2'd2, 1'b0, 1'b0);
    random_bounds(lo, hi, 1'b1);
    run_phase(lo, hi, 2'($urandom), 1'b0, 1'b0);
    random_bounds(lo, hi, 1'b0);
    run_phase(lo, hi, CHSEL_ALL, 1'b1, 1'b0);
    random_bounds(lo, hi, 1'b0);
    run_phase(lo, hi, CHSEL_ALL, 1'b0, 1'b1);
    drain();

    $display("run: %0d items, %0d results checked, %0d bound settings, %0d mismatches",
             sb.noted, sb.checked, phases, sb.mismatches);
    $display("covered refused starts, zero-area boxes, density ceiling, long stall");
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ctbt_pkg.sv
rtl/ctbt_div.sv
rtl/ctbt_ctrl.sv
rtl/ctbt_dpath.sv
rtl/color_threshold_blob_tracker.sv
rtl/ctbt_checker.sv
test/tb_color_threshold_blob_tracker.sv
